[src/sss_pkg.sv]
// ---------------------------------------------------------------------------
// sss_pkg
// Shared widths, the set summary record and the back end state type for the
// streaming sample statistics block.
// ---------------------------------------------------------------------------
package sss_pkg;

  // Design constants
  localparam int COUNT_BITS    = 20;
  localparam int FRACTION_BITS = 8;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int TOTAL_W   = 36;
  localparam int AVG_W     = 24;
  localparam int VAR_W     = 38;
  localparam int DEV_W     = 23;
  localparam int CNT_OUT_W = 21;

  // Internal widths
  localparam int N_W       = COUNT_BITS + 1;          // count up to 2^COUNT_BITS
  localparam int SUM_W     = SAMPLE_W + COUNT_BITS;   // signed running sum
  localparam int MAG_W     = SUM_W;                   // |sum|
  localparam int SQ1_W     = 2 * SAMPLE_W - 1;        // one square, at most 2^30
  localparam int SQS_W     = SQ1_W + COUNT_BITS;      // sum of squares
  localparam int PROD_W    = N_W + SQS_W;             // n*sumsq and sum^2
  localparam int NSQ_W     = 2 * N_W;                 // n^2
  localparam int DIV_W     = PROD_W + 2 * FRACTION_BITS;
  localparam int AVG_NUM_W = MAG_W + FRACTION_BITS;
  localparam int ROOT_W    = DEV_W + 1;
  localparam int SQ_IN_W   = 2 * ROOT_W;

  // Iteration counts of the back end
  localparam int MUL_STEPS  = MAG_W;
  localparam int DIV_STEPS  = DIV_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Summary of one closed set
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SUM_W-1:0]    total;
    logic [SQS_W-1:0]           square_sum;
    logic [N_W-1:0]             count;
    logic                       overflow;
  } sss_job_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_DIFF,
    BS_DIV,
    BS_SPREP,
    BS_ROOT,
    BS_DONE
  } back_state_e;

endpackage

[src/sss_front.sv]
// ---------------------------------------------------------------------------
// sss_front
// Accepts one sample per cycle unless stalled, squares it, keeps the running
// min, max, sum, square sum, count; pushes a set summary on the last sample.
// ---------------------------------------------------------------------------
module sss_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output sss_pkg::sss_job_t                   job_o
);
  import sss_pkg::*;

  // Stage 1: registered sample and its square
  logic                       s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic [SQ1_W-1:0]           s1_sq_q;
  logic                       s1_last_q;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic                       advance;

  // Stage 2: accumulators
  logic signed [SAMPLE_W-1:0] min_q, min_d, max_q, max_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [SQS_W-1:0]           sq_q, sq_d;
  logic [N_W-1:0]             cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;
  logic signed [SUM_W-1:0]    sample_ext;
  logic                       full;
  logic                       first;

  // The pipe only halts when a closing item cannot enter the queue
  assign advance    = !(s1_valid_q && s1_last_q && q_full_i);
  assign in_stall_o = !advance;
  assign s1_valid_d = advance ? in_valid_i : s1_valid_q;
  assign prod       = sample_i * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      s1_sample_q <= sample_i;
      s1_sq_q     <= prod[SQ1_W-1:0];
      s1_last_q   <= last_i;
    end
  end

  // Next accumulator values for the item in stage 1
  assign full       = cnt_q[COUNT_BITS];
  assign first      = (cnt_q == '0);
  assign sample_ext = {{COUNT_BITS{s1_sample_q[SAMPLE_W-1]}}, s1_sample_q};

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    sum_d = sum_q;
    sq_d  = sq_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (full) begin
      ovf_d = 1'b1;   // dropped sample
    end else begin
      if (first || (s1_sample_q < min_q)) min_d = s1_sample_q;
      if (first || (s1_sample_q > max_q)) max_d = s1_sample_q;
      sum_d = sum_q + sample_ext;
      sq_d  = sq_q + SQS_W'(s1_sq_q);
      cnt_d = cnt_q + N_W'(1);
    end
  end

  // Summary handed to the queue
  assign push_o = s1_valid_q && s1_last_q && !q_full_i;
  always_comb begin
    job_o.minimum    = min_d;
    job_o.maximum    = max_d;
    job_o.total      = sum_d;
    job_o.square_sum = sq_d;
    job_o.count      = cnt_d;
    job_o.overflow   = ovf_d;
  end

  // Accumulators, cleared when a set closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (s1_valid_q && advance) begin
      if (s1_last_q) begin
        min_q <= '0;
        max_q <= '0;
        sum_q <= '0;
        sq_q  <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        min_q <= min_d;
        max_q <= max_d;
        sum_q <= sum_d;
        sq_q  <= sq_d;
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
      end
    end
  end

endmodule

[src/sss_queue.sv]
// ---------------------------------------------------------------------------
// sss_queue
// Short FIFO of set summaries between the front and the back end.
// ---------------------------------------------------------------------------
module sss_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sss_pkg::sss_job_t push_job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output sss_pkg::sss_job_t head_o
);
  import sss_pkg::*;

  sss_job_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

[src/sss_back.sv]
// ---------------------------------------------------------------------------
// sss_back
// Works one set summary at a time: shift-add products for n*sumsq and sum^2,
// bit-serial restoring division for mean and variance, digit-by-digit square
// root for the deviation, then saturation into the output register.
// ---------------------------------------------------------------------------
module sss_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  sss_pkg::sss_job_t                    job_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sss_pkg::SAMPLE_W-1:0]  minimum_o,
  output logic signed [sss_pkg::SAMPLE_W-1:0]  maximum_o,
  output logic signed [sss_pkg::TOTAL_W-1:0]   total_o,
  output logic signed [sss_pkg::AVG_W-1:0]     average_q8_o,
  output logic [sss_pkg::VAR_W-1:0]            spread_q8_o,
  output logic [sss_pkg::DEV_W-1:0]            deviation_q8_o,
  output logic [sss_pkg::CNT_OUT_W-1:0]        sample_count_o,
  output logic                                 count_overflow_o
);
  import sss_pkg::*;

  localparam int AW  = AVG_NUM_W + AVG_W;
  localparam int VW  = DIV_W + VAR_W;
  localparam int SW  = DIV_W + SQ_IN_W;
  localparam int CW  = N_W + CNT_OUT_W;
  localparam int TWW = SUM_W + TOTAL_W;

  back_state_e         state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                step_zero;
  logic                out_free;
  logic                out_load;
  logic                out_valid_q, out_valid_d;

  // Working registers
  sss_job_t            job_q;
  logic [MAG_W-1:0]    mag_q, mag_in;
  logic [PROD_W-1:0]   mp_add_q, ms_add_q, acc_p_q, acc_s_q;
  logic [N_W-1:0]      mp_mul_q;
  logic [MAG_W-1:0]    ms_mul_q;
  logic [NSQ_W-1:0]    nsq_q;
  logic [DIV_W-1:0]    dv_num_q, dv_quo_q, av_num_q;
  logic [NSQ_W-1:0]    dv_rem_q;
  logic [N_W-1:0]      av_rem_q;
  logic [AVG_NUM_W-1:0] av_quo_q;
  logic [SQ_IN_W-1:0]  sq_op_q;
  logic [ROOT_W:0]     sq_rem_q;
  logic [ROOT_W-1:0]   root_q;

  // Step datapath signals
  logic [NSQ_W:0]      dv_r2, dv_diff;
  logic                dv_ge;
  logic [N_W:0]        av_r2, av_diff;
  logic                av_ge;
  logic [ROOT_W+2:0]   sq_r2, sq_trial, sq_diff;
  logic                sq_ge;
  logic [SW-1:0]       sq_in_w;
  logic [SQ_IN_W-1:0]  sq_in;

  // Final saturation
  logic [AW-1:0]       avg_w, avg_lim;
  logic [AVG_W-1:0]    avg_c;
  logic [DIV_W-1:0]    var_raw;
  logic [VW-1:0]       var_w;
  logic [CW-1:0]       cnt_w;
  logic signed [TWW-1:0] tot_w, tot_hi, tot_lo, tot_c;
  logic                neg;

  assign step_zero = (step_q == '0);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE:  if (q_valid_i) state_d = BS_MUL;
      BS_MUL:   if (step_zero) state_d = BS_DIFF;
      BS_DIFF:  state_d = BS_DIV;
      BS_DIV:   if (step_zero) state_d = BS_SPREP;
      BS_SPREP: state_d = BS_ROOT;
      BS_ROOT:  if (step_zero) state_d = BS_DONE;
      BS_DONE:  if (out_free) state_d = BS_IDLE;
      default:  state_d = BS_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    step_d   = step_q;
    case (state_q)
      BS_IDLE: begin
        pop_o  = q_valid_i;
        step_d = STEP_W'(MUL_STEPS - 1);
      end
      BS_MUL, BS_DIV, BS_ROOT: begin
        step_d = step_q - STEP_W'(1);
      end
      BS_DIFF:  step_d = STEP_W'(DIV_STEPS - 1);
      BS_SPREP: step_d = STEP_W'(ROOT_STEPS - 1);
      BS_DONE:  out_load = out_free;
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Magnitude of the sum at pop
  assign mag_in = job_i.total[SUM_W-1] ? MAG_W'(~job_i.total + SUM_W'(1))
                                       : MAG_W'(job_i.total);

  // Restoring division steps: variance by n^2, mean by n
  assign dv_r2   = {dv_rem_q, dv_num_q[DIV_W-1]};
  assign dv_diff = dv_r2 - {1'b0, nsq_q};
  assign dv_ge   = (dv_r2 >= {1'b0, nsq_q});
  assign av_r2   = {av_rem_q, av_num_q[DIV_W-1]};
  assign av_diff = av_r2 - {1'b0, job_q.count};
  assign av_ge   = (av_r2 >= {1'b0, job_q.count});

  // Square root step, two operand bits per cycle
  assign sq_r2    = {sq_rem_q, sq_op_q[SQ_IN_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_diff  = sq_r2 - sq_trial;
  assign sq_ge    = (sq_r2 >= sq_trial);

  // Variance with fraction bits, clamped into the root operand
  assign sq_in_w = SW'(dv_quo_q);
  assign sq_in   = (sq_in_w > SW'({SQ_IN_W{1'b1}})) ? {SQ_IN_W{1'b1}} : sq_in_w[SQ_IN_W-1:0];

  always_ff @(posedge clk_i) begin
    case (state_q)
      BS_IDLE: begin
        if (q_valid_i) begin
          job_q    <= job_i;
          mag_q    <= mag_in;
          acc_p_q  <= '0;
          acc_s_q  <= '0;
          mp_add_q <= PROD_W'(job_i.square_sum);
          mp_mul_q <= job_i.count;
          ms_add_q <= PROD_W'(mag_in);
          ms_mul_q <= mag_in;
        end
      end
      BS_MUL: begin
        if (mp_mul_q[0]) acc_p_q <= acc_p_q + mp_add_q;
        if (ms_mul_q[0]) acc_s_q <= acc_s_q + ms_add_q;
        mp_add_q <= mp_add_q << 1;
        ms_add_q <= ms_add_q << 1;
        mp_mul_q <= mp_mul_q >> 1;
        ms_mul_q <= ms_mul_q >> 1;
      end
      BS_DIFF: begin
        dv_num_q <= DIV_W'(acc_p_q - acc_s_q) << (2 * FRACTION_BITS);
        av_num_q <= DIV_W'(mag_q) << FRACTION_BITS;
        nsq_q    <= job_q.count * job_q.count;
        dv_rem_q <= '0;
        dv_quo_q <= '0;
        av_rem_q <= '0;
        av_quo_q <= '0;
      end
      BS_DIV: begin
        dv_rem_q <= dv_ge ? dv_diff[NSQ_W-1:0] : dv_r2[NSQ_W-1:0];
        dv_quo_q <= {dv_quo_q[DIV_W-2:0], dv_ge};
        dv_num_q <= dv_num_q << 1;
        av_rem_q <= av_ge ? av_diff[N_W-1:0] : av_r2[N_W-1:0];
        av_quo_q <= {av_quo_q[AVG_NUM_W-2:0], av_ge};
        av_num_q <= av_num_q << 1;
      end
      BS_SPREP: begin
        sq_op_q  <= sq_in;
        sq_rem_q <= '0;
        root_q   <= '0;
      end
      BS_ROOT: begin
        sq_rem_q <= sq_ge ? sq_diff[ROOT_W:0] : sq_r2[ROOT_W:0];
        root_q   <= {root_q[ROOT_W-2:0], sq_ge};
        sq_op_q  <= sq_op_q << 2;
      end
      default: begin
        job_q <= job_q;
      end
    endcase
  end

  // Saturation of the results
  assign neg     = job_q.total[SUM_W-1];
  assign avg_w   = AW'(av_quo_q);
  assign avg_lim = neg ? AW'(2 ** (AVG_W - 1)) : AW'(2 ** (AVG_W - 1) - 1);
  assign avg_c   = (avg_w > avg_lim) ? avg_lim[AVG_W-1:0] : avg_w[AVG_W-1:0];

  assign var_raw = dv_quo_q >> FRACTION_BITS;
  assign var_w   = VW'(var_raw);
  assign cnt_w   = CW'(job_q.count);

  assign tot_w  = TWW'(job_q.total);
  assign tot_hi = {{(SUM_W + 1){1'b0}}, {(TOTAL_W - 1){1'b1}}};
  assign tot_lo = {{(SUM_W + 1){1'b1}}, {(TOTAL_W - 1){1'b0}}};
  assign tot_c  = (tot_w > tot_hi) ? tot_hi : ((tot_w < tot_lo) ? tot_lo : tot_w);

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      minimum_o        <= job_q.minimum;
      maximum_o        <= job_q.maximum;
      total_o          <= tot_c[TOTAL_W-1:0];
      average_q8_o     <= neg ? (~avg_c + AVG_W'(1)) : avg_c;
      spread_q8_o      <= (var_w > VW'({VAR_W{1'b1}})) ? {VAR_W{1'b1}} : var_w[VAR_W-1:0];
      deviation_q8_o   <= root_q[ROOT_W-1] ? {DEV_W{1'b1}} : root_q[DEV_W-1:0];
      sample_count_o   <= (cnt_w > CW'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
                                                           : cnt_w[CNT_OUT_W-1:0];
      count_overflow_o <= job_q.overflow;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/streaming_sample_statistics.sv]
// ---------------------------------------------------------------------------
// streaming_sample_statistics
// Min, max, sum, mean, population variance and standard deviation of a
// stream of signed 16-bit samples, one result per set.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample per item; the
//   item with last_i set closes the set. One sample per cycle unless stalled.
//   Output channel (out_valid_o / out_stall_i) carries one result per set.
//   The back end is built from serial units: 36 shift-add steps for n*sumsq
//   and sum^2, 88 restoring division steps (mean and variance side by side)
//   and 24 square root steps, worked on one set at a time.
//   Two closed sets can wait in the queue; while it is full and another set
//   closes, in_stall_o rises until the back end frees an entry.
//   A stalled result holds in the output register; the back end finishes
//   the next set and waits for that register to drain.
//   More than 2^20 samples in a set: extra samples are dropped and
//   count_overflow_o is set with the result.
//   Reset clears all accumulators, the queue and the output valid.
// ---------------------------------------------------------------------------
module streaming_sample_statistics (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [sss_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sss_pkg::SAMPLE_W-1:0]  minimum_o,
  output logic signed [sss_pkg::SAMPLE_W-1:0]  maximum_o,
  output logic signed [sss_pkg::TOTAL_W-1:0]   total_o,
  output logic signed [sss_pkg::AVG_W-1:0]     average_q8_o,
  output logic [sss_pkg::VAR_W-1:0]            spread_q8_o,
  output logic [sss_pkg::DEV_W-1:0]            deviation_q8_o,
  output logic [sss_pkg::CNT_OUT_W-1:0]        sample_count_o,
  output logic                                 count_overflow_o
);
  import sss_pkg::*;

  logic     push, q_full, q_valid, pop;
  sss_job_t push_job, head_job;

  // Front: accumulate samples
  sss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Queue of closed sets
  sss_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  // Back: products, divisions, square root
  sss_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .job_i            (head_job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .minimum_o        (minimum_o),
    .maximum_o        (maximum_o),
    .total_o          (total_o),
    .average_q8_o     (average_q8_o),
    .spread_q8_o      (spread_q8_o),
    .deviation_q8_o   (deviation_q8_o),
    .sample_count_o   (sample_count_o),
    .count_overflow_o (count_overflow_o)
  );

endmodule

[src/sss_checker.sv]
// ---------------------------------------------------------------------------
// sss_checker
// Port-level checks on the streaming sample statistics block.
// ---------------------------------------------------------------------------
module sss_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [sss_pkg::SAMPLE_W-1:0]  sample_i,
  input logic                                 last_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [sss_pkg::SAMPLE_W-1:0]  minimum_o,
  input logic signed [sss_pkg::SAMPLE_W-1:0]  maximum_o,
  input logic signed [sss_pkg::TOTAL_W-1:0]   total_o,
  input logic signed [sss_pkg::AVG_W-1:0]     average_q8_o,
  input logic [sss_pkg::VAR_W-1:0]            spread_q8_o,
  input logic [sss_pkg::DEV_W-1:0]            deviation_q8_o,
  input logic [sss_pkg::CNT_OUT_W-1:0]        sample_count_o,
  input logic                                 count_overflow_o
);
  import sss_pkg::*;

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_o)
      && $stable(spread_q8_o) && $stable(sample_count_o))
    else $error("result changed while stalled");

  // Every set holds at least one sample and min does not exceed max
  a_set_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != '0) && (minimum_o <= maximum_o))
    else $error("empty set or min above max");

  // Mean lies between min and max
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (average_q8_o >= (minimum_o * (2 ** FRACTION_BITS)))
      && (average_q8_o <= (maximum_o * (2 ** FRACTION_BITS))))
    else $error("mean outside sample range");

  // Deviation squared agrees with the variance
  a_dev_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (64'(deviation_q8_o) * 64'(deviation_q8_o))
      < ((64'(spread_q8_o) + 64'd1) << FRACTION_BITS))
    else $error("deviation inconsistent with variance");

endmodule

bind streaming_sample_statistics sss_checker u_sss_checker (.*);
